/* sv/bhef_pkg.sv */
// ----------------------------------------------------------------------------
// bhef_pkg
// Shared widths, character codes and scan modes of the bencode header end
// finder.
// ----------------------------------------------------------------------------
package bhef_pkg;

   localparam int DEPTH_BITS    = 9;
   localparam int LENGTH_BITS   = 24;
   localparam int POSITION_BITS = 21;
   localparam int HDR_LEN_BITS  = 21;
   localparam int ACCUM_BITS    = LENGTH_BITS + 4;

   localparam logic [DEPTH_BITS-1:0]    DEPTH_MAX    = {DEPTH_BITS{1'b1}};
   localparam logic [LENGTH_BITS-1:0]   LENGTH_MAX   = {LENGTH_BITS{1'b1}};
   localparam logic [POSITION_BITS-1:0] POSITION_MAX = {POSITION_BITS{1'b1}};
   localparam logic [HDR_LEN_BITS-1:0]  HDR_LEN_LIMIT = HDR_LEN_BITS'(1048576);

   localparam logic [7:0] CHAR_D    = 8'h64;
   localparam logic [7:0] CHAR_L    = 8'h6C;
   localparam logic [7:0] CHAR_E    = 8'h65;
   localparam logic [7:0] CHAR_I    = 8'h69;
   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_NORMAL  = 2'd0;
   localparam mode_type MODE_INTEGER = 2'd1;
   localparam mode_type MODE_DIGITS  = 2'd2;
   localparam mode_type MODE_SKIP    = 2'd3;

endpackage

/* sv/bencode_header_end_finder.sv */
// ----------------------------------------------------------------------------
// bencode_header_end_finder
// Scans message bytes and marks where the leading bencoded dictionary or list ends.
// ----------------------------------------------------------------------------
//  Channel | Direction | tdata (low bit up)                  | tuser / tlast
//  req     | in        | [7:0] data_byte                     | tlast end_of_message
//  rsp     | out       | [7:0] byte_out, [28:8] header_length| tuser is_payload,
//          |           |                                     | closes_header,
//          |           |                                     | header_found; tlast
//
//  One word per cycle unless the result is stalled. Each word passes through one
//  stage: the scan state and the result register are updated at the edge the word
//  is accepted, and the result appears in the following cycle. A stalled result
//  holds while a new word is accepted in the cycle the result is taken. Reset is
//  synchronous, holds the input off and clears the scan state and the result valid;
//  the state also clears after the last word of a message.
// ----------------------------------------------------------------------------
module bencode_header_end_finder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] byte_out, [28:8] header_length, zero fill
   output logic [2:0]  rsp_tuser,   // [0] is_payload, [1] closes_header, [2] header_found
   output logic        rsp_tlast
);

   bhef_pkg::mode_type                       mode_ff, mode_in;
   logic [bhef_pkg::DEPTH_BITS-1:0]          depth_ff, depth_in;
   logic [bhef_pkg::LENGTH_BITS-1:0]         accum_ff, accum_in;
   logic [bhef_pkg::LENGTH_BITS-1:0]         skip_ff, skip_in;
   logic [bhef_pkg::POSITION_BITS-1:0]       position_ff, position_in;
   logic                                     closed_ff, closed_in;
   logic [bhef_pkg::POSITION_BITS-1:0]       closed_len_ff, closed_len_in;

   logic                                     rsp_valid_ff, rsp_valid_in;
   logic [31:0]                              rsp_data_ff, rsp_data_in;
   logic [2:0]                               rsp_user_ff, rsp_user_in;
   logic                                     rsp_last_ff, rsp_last_in;

   logic                                     accept;
   logic                                     is_digit;
   logic                                     closing;
   logic [3:0]                               digit;
   logic [bhef_pkg::ACCUM_BITS-1:0]          accum_wide;
   logic [bhef_pkg::LENGTH_BITS-1:0]         skip_dec;
   logic [bhef_pkg::HDR_LEN_BITS-1:0]        hdr_len;

   assign req_tready = !reset && (!rsp_valid_ff || rsp_tready);
   assign accept     = req_tvalid && req_tready;

   assign is_digit   = req_tdata inside {[bhef_pkg::CHAR_ZERO:bhef_pkg::CHAR_NINE]};
   assign digit      = 4'(req_tdata - bhef_pkg::CHAR_ZERO);
   assign accum_wide = {1'b0, accum_ff, 3'b000} + {3'b000, accum_ff, 1'b0}
                       + bhef_pkg::ACCUM_BITS'(digit);
   assign skip_dec   = (skip_ff != '0) ? skip_ff - 1'b1 : skip_ff;

   always_comb begin
      mode_in       = mode_ff;
      depth_in      = depth_ff;
      accum_in      = accum_ff;
      skip_in       = skip_ff;
      closed_in     = closed_ff;
      closed_len_in = closed_len_ff;
      closing       = 1'b0;
      position_in   = (position_ff != bhef_pkg::POSITION_MAX) ? position_ff + 1'b1
                                                              : position_ff;
      if (!closed_ff) begin
         case (mode_ff)
            bhef_pkg::MODE_INTEGER: begin
               if (req_tdata == bhef_pkg::CHAR_E) begin
                  mode_in = bhef_pkg::MODE_NORMAL;
               end
            end
            bhef_pkg::MODE_DIGITS: begin
               if (is_digit) begin
                  accum_in = (accum_wide > bhef_pkg::ACCUM_BITS'(bhef_pkg::LENGTH_MAX))
                             ? bhef_pkg::LENGTH_MAX
                             : accum_wide[bhef_pkg::LENGTH_BITS-1:0];
               end else begin
                  skip_in  = accum_ff;
                  accum_in = '0;
                  mode_in  = (accum_ff != '0) ? bhef_pkg::MODE_SKIP : bhef_pkg::MODE_NORMAL;
               end
            end
            bhef_pkg::MODE_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == '0) begin
                  mode_in = bhef_pkg::MODE_NORMAL;
               end
            end
            default: begin
               if (req_tdata == bhef_pkg::CHAR_D || req_tdata == bhef_pkg::CHAR_L) begin
                  if (depth_ff != bhef_pkg::DEPTH_MAX) begin
                     depth_in = depth_ff + 1'b1;
                  end
               end else if (req_tdata == bhef_pkg::CHAR_E) begin
                  if (depth_ff != '0) begin
                     depth_in = depth_ff - 1'b1;
                     if (depth_ff == bhef_pkg::DEPTH_BITS'(1)) begin
                        closing       = 1'b1;
                        closed_in     = 1'b1;
                        closed_len_in = position_in;
                     end
                  end
               end else if (req_tdata == bhef_pkg::CHAR_I) begin
                  mode_in = bhef_pkg::MODE_INTEGER;
               end else if (is_digit) begin
                  accum_in = bhef_pkg::LENGTH_BITS'(digit);
                  mode_in  = bhef_pkg::MODE_DIGITS;
               end
            end
         endcase
      end

      if (!closed_in) begin
         hdr_len = '0;
      end else if (closed_len_in > bhef_pkg::HDR_LEN_LIMIT) begin
         hdr_len = bhef_pkg::HDR_LEN_LIMIT;
      end else begin
         hdr_len = closed_len_in;
      end

      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_last_in  = rsp_last_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, hdr_len, req_tdata};
         rsp_user_in  = {req_tlast && closed_in, closing, closed_ff};
         rsp_last_in  = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= bhef_pkg::MODE_NORMAL;
         depth_ff      <= '0;
         accum_ff      <= '0;
         skip_ff       <= '0;
         position_ff   <= '0;
         closed_ff     <= 1'b0;
         closed_len_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            if (req_tlast) begin
               mode_ff       <= bhef_pkg::MODE_NORMAL;
               depth_ff      <= '0;
               accum_ff      <= '0;
               skip_ff       <= '0;
               position_ff   <= '0;
               closed_ff     <= 1'b0;
               closed_len_ff <= '0;
            end else begin
               mode_ff       <= mode_in;
               depth_ff      <= depth_in;
               accum_ff      <= accum_in;
               skip_ff       <= skip_in;
               position_ff   <= position_in;
               closed_ff     <= closed_in;
               closed_len_ff <= closed_len_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bencode header end finder. Messages are built
// as byte streams: short directed cases, then random well-formed dictionaries
// with payload, broken dictionaries and noise. Every accepted byte is run
// through a local scan model. The result stream is compared word by word in
// order while both sides idle at random and the receiver holds off for long
// stretches.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [7:0]                        data;
      logic                              payload;
      logic                              closes;
      logic [bhef_pkg::HDR_LEN_BITS-1:0] hdr_len;
      logic                              done;
      logic                              found;
   } scan_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        rsp_tlast;

   req_word_type    msg_bytes[$];
   scan_result_type scan_results_due[$];
   int              words_total = -1;
   int              words_sent = 0;
   int              fail_count = 0;
   int              cycle_count = 0;
   int              hold_left = 0;
   logic            quiet;

   bhef_pkg::mode_type                 sc_mode;
   logic [bhef_pkg::DEPTH_BITS-1:0]    sc_depth;
   logic [bhef_pkg::LENGTH_BITS-1:0]   sc_len_acc;
   logic [bhef_pkg::LENGTH_BITS-1:0]   sc_skip_left;
   logic [bhef_pkg::POSITION_BITS-1:0] sc_pos;
   logic [bhef_pkg::POSITION_BITS-1:0] sc_close_len;
   logic                               sc_closed;

   bencode_header_end_finder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void clear_scan();
      sc_mode      = bhef_pkg::MODE_NORMAL;
      sc_depth     = '0;
      sc_len_acc   = '0;
      sc_skip_left = '0;
      sc_pos       = '0;
      sc_close_len = '0;
      sc_closed    = 1'b0;
   endfunction

   function automatic scan_result_type scan_byte(input logic [7:0] b, input logic last);
      scan_result_type r;
      logic            was_closed;
      logic            closing;
      logic            digit;
      longint unsigned acc;
      was_closed = sc_closed;
      closing = 1'b0;
      digit = (b >= bhef_pkg::CHAR_ZERO) && (b <= bhef_pkg::CHAR_NINE);
      if (sc_pos != bhef_pkg::POSITION_MAX) sc_pos = sc_pos + 1'b1;
      if (!was_closed) begin
         case (sc_mode)
            bhef_pkg::MODE_INTEGER: begin
               if (b == bhef_pkg::CHAR_E) sc_mode = bhef_pkg::MODE_NORMAL;
            end
            bhef_pkg::MODE_DIGITS: begin
               if (digit) begin
                  acc = 64'(sc_len_acc) * 64'd10 + 64'(b) - 64'(bhef_pkg::CHAR_ZERO);
                  sc_len_acc = (acc > 64'(bhef_pkg::LENGTH_MAX)) ? bhef_pkg::LENGTH_MAX
                                                                 : acc[bhef_pkg::LENGTH_BITS-1:0];
               end else begin
                  sc_skip_left = sc_len_acc;
                  sc_len_acc = '0;
                  sc_mode = (sc_skip_left != 0) ? bhef_pkg::MODE_SKIP : bhef_pkg::MODE_NORMAL;
               end
            end
            bhef_pkg::MODE_SKIP: begin
               if (sc_skip_left != 0) sc_skip_left = sc_skip_left - 1'b1;
               if (sc_skip_left == 0) sc_mode = bhef_pkg::MODE_NORMAL;
            end
            default: begin
               if (b == bhef_pkg::CHAR_D || b == bhef_pkg::CHAR_L) begin
                  if (sc_depth != bhef_pkg::DEPTH_MAX) sc_depth = sc_depth + 1'b1;
               end else if (b == bhef_pkg::CHAR_E) begin
                  if (sc_depth != 0) begin
                     sc_depth = sc_depth - 1'b1;
                     if (sc_depth == 0) begin
                        closing = 1'b1;
                        sc_closed = 1'b1;
                        sc_close_len = sc_pos;
                     end
                  end
               end else if (b == bhef_pkg::CHAR_I) begin
                  sc_mode = bhef_pkg::MODE_INTEGER;
               end else if (digit) begin
                  sc_len_acc = bhef_pkg::LENGTH_BITS'(b - bhef_pkg::CHAR_ZERO);
                  sc_mode = bhef_pkg::MODE_DIGITS;
               end
            end
         endcase
      end
      r.data    = b;
      r.payload = was_closed;
      r.closes  = closing;
      r.hdr_len = '0;
      if (sc_closed)
         r.hdr_len = (sc_close_len > bhef_pkg::HDR_LEN_LIMIT) ? bhef_pkg::HDR_LEN_LIMIT
                                                               : sc_close_len;
      r.done  = last;
      r.found = last && sc_closed;
      if (last) clear_scan();
      return r;
   endfunction

   task automatic push_byte(input logic [7:0] b);
      req_word_type w;
      w.data = b;
      w.last = 1'b0;
      msg_bytes.insert(msg_bytes.size(), w);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic end_message();
      msg_bytes[msg_bytes.size()-1].last = 1'b1;
   endtask

   function automatic logic [7:0] random_byte();
      string specials;
      specials = "dlie0123456789:-";
      if ($urandom_range(1) == 0) return specials[$urandom_range(specials.len()-1)];
      return 8'($urandom_range(255));
   endfunction

   task automatic push_string();
      int len;
      len = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(5);
      if ($urandom_range(9) == 0) push_byte(bhef_pkg::CHAR_ZERO);
      push_text($sformatf("%0d:", len));
      for (int i = 0; i < len; i++) push_byte(random_byte());
   endtask

   task automatic push_integer();
      int n;
      n = $urandom_range(1, 4);
      push_byte(bhef_pkg::CHAR_I);
      if ($urandom_range(3) == 0) push_text("-");
      for (int i = 0; i < n; i++) push_byte(bhef_pkg::CHAR_ZERO + 8'($urandom_range(9)));
      push_byte(bhef_pkg::CHAR_E);
   endtask

   task automatic push_dict();
      int depth;
      int n;
      int pick;
      push_byte(bhef_pkg::CHAR_D);
      depth = 1;
      n = 0;
      while (depth > 0) begin
         pick = $urandom_range(9);
         if (n > 30 || pick < 2) begin
            push_byte(bhef_pkg::CHAR_E);
            depth--;
         end else if (pick < 4 && depth < 5) begin
            push_byte(($urandom_range(1) == 0) ? bhef_pkg::CHAR_D : bhef_pkg::CHAR_L);
            depth++;
         end else if (pick < 6) begin
            push_integer();
         end else begin
            push_string();
         end
         n++;
      end
   endtask

   initial begin : stimulus
      int kind;
      int cut;
      clear_scan();

      // Stray close at depth zero, empty string, then payload at the byte extremes.
      push_text("ed0:e");
      push_byte(8'h00);
      push_byte(8'hFF);
      end_message();
      // Closing bytes hidden inside an integer and a string.
      push_text("li9e2:eeed");
      end_message();
      // Message that ends inside an integer.
      push_text("di4");
      end_message();
      // Header closing on the final byte of its message.
      push_text("de");
      end_message();
      // String length far beyond the counter range.
      push_text("d99999999:e");
      end_message();

      while (msg_bytes.size() < 950) begin
         kind = $urandom_range(19);
         if (kind < 14) begin
            push_dict();
            for (int i = $urandom_range(12); i > 0; i--) push_byte(8'($urandom_range(255)));
         end else if (kind < 17) begin
            cut = msg_bytes.size();
            push_dict();
            cut = msg_bytes.size() - cut;
            if (cut > 1)
               for (int i = $urandom_range(1, cut - 1); i > 0; i--) void'(msg_bytes.pop_back());
         end else begin
            for (int i = $urandom_range(1, 30); i > 0; i--) push_byte(random_byte());
         end
         end_message();
      end
      words_total = msg_bytes.size();

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (words_sent != words_total || scan_results_due.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("[bencode_header_end_finder] OK");
      end else begin
         $display("[bencode_header_end_finder] ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #2ms;
      $display("[bencode_header_end_finder] ERROR");
      $finish;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   assign quiet = (cycle_count >= 1000) && (cycle_count < 1500);

   always @(posedge clock) begin : driver
      req_word_type w;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            scan_results_due.insert(scan_results_due.size(), scan_byte(req_tdata, req_tlast));
            words_sent <= words_sent + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (msg_bytes.size() != 0 && (quiet || $urandom_range(99) >= 16)) begin
               w = msg_bytes.pop_front();
               req_tdata  <= w.data;
               req_tlast  <= w.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left  <= 0;
      end else if (hold_left != 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (cycle_count == 300 || cycle_count == 2200) begin
         rsp_tready <= 1'b0;
         hold_left  <= 200;
      end else begin
         rsp_tready <= quiet || ($urandom_range(99) >= 16);
      end
   end

   always @(posedge clock) begin : monitor
      scan_result_type got;
      scan_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.data    = rsp_tdata[7:0];
         got.payload = rsp_tuser[0];
         got.closes  = rsp_tuser[1];
         got.hdr_len = rsp_tdata[28:8];
         got.done    = rsp_tlast;
         got.found   = rsp_tuser[2];
         if (scan_results_due.size() == 0) begin
            if (fail_count < 10)
               $display("unexpected word: byte=%02h", got.data);
            fail_count <= fail_count + 1;
         end else begin
            want = scan_results_due.pop_front();
            if (got != want) begin
               if (fail_count < 10)
                  $display({"mismatch: expected byte=%02h payload=%0b closes=%0b len=%0d ",
                            "last=%0b found=%0b, got byte=%02h payload=%0b closes=%0b ",
                            "len=%0d last=%0b found=%0b"},
                           want.data, want.payload, want.closes, want.hdr_len, want.done,
                           want.found, got.data, got.payload, got.closes, got.hdr_len,
                           got.done, got.found);
               fail_count <= fail_count + 1;
            end
         end
      end
   end

endmodule
